// ----- rtl/ppt_pkg.sv -----
// Shared types, codes and helper functions of the pointer position tracker.
package ppt_pkg;

  // Fixed field widths of the two channels and the configuration port.
  localparam int COORD_W  = 16;
  localparam int DEV_W    = 8;
  localparam int BTN_W    = 3;
  localparam int MASK_W   = 8;
  localparam int REPORT_W = 12;
  localparam int KIND_W   = 3;
  localparam int CMD_W    = 2;
  localparam int VIEW_W   = 13;
  localparam int CFG_IDX_W = 1;

  // Block constants.
  localparam int MAX_VIEW     = 4096;
  localparam int BUTTON_COUNT = 8;
  localparam int QUEUE_DEPTH  = 2;

  // Cursor width follows the largest view; the target sum needs room for the
  // cursor plus a full signed delta.
  localparam int CUR_W = $clog2(MAX_VIEW);
  localparam int SUM_W = ((CUR_W + 1 > COORD_W) ? CUR_W + 1 : COORD_W) + 1;
  localparam int LIM_CALC_W = 17;

  localparam logic [VIEW_W-1:0] VIEW_WIDTH_RESET  = 13'd640;
  localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RESET = 13'd480;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 1'b1;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

  // Decoded operations handed from the front end to the execute stage.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP      = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE_ABS = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE_REL = 3'd2;
  localparam logic [OP_W-1:0] OP_BTN_SET  = 3'd3;
  localparam logic [OP_W-1:0] OP_BTN_CLR  = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      is_relative;
    logic [BTN_W-1:0]          button_index;
    logic                      pressed;
    logic [DEV_W-1:0]          source_device;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         event_kind;
    logic [DEV_W-1:0]          event_device;
    logic [BTN_W-1:0]          event_button;
    logic [MASK_W-1:0]         button_state;
    logic [REPORT_W-1:0]       report_x;
    logic [REPORT_W-1:0]       report_y;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [BTN_W-1:0]          button_index;
    logic [DEV_W-1:0]          device;
    logic                      quiet;
  } op_t;

  // Largest legal coordinate for a view register: out-of-range sizes are
  // pulled into [1, MAX_VIEW] first.
  function automatic logic [CUR_W-1:0] view_limit(input logic [VIEW_W-1:0] size);
    logic [LIM_CALC_W-1:0] eff;
    logic [LIM_CALC_W-1:0] lim;
    eff = {{(LIM_CALC_W-VIEW_W){1'b0}}, size};
    if (size == '0) begin
      eff = LIM_CALC_W'(1);
    end else if (eff > LIM_CALC_W'(MAX_VIEW)) begin
      eff = LIM_CALC_W'(MAX_VIEW);
    end
    lim = eff - LIM_CALC_W'(1);
    return lim[CUR_W-1:0];
  endfunction

  // Signed 16-bit add that sticks at the rails instead of wrapping.
  function automatic logic [COORD_W-1:0] sat_add16(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    logic [COORD_W-1:0] r;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ppt_fifo.sv -----
// Small register queue used between the pipeline parts and on the result side.
module ppt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/ppt_front.sv -----
// Front end: accepts input beats and decodes them into execute operations.
module ppt_front (
  input  logic             in_push,
  input  ppt_pkg::in_item_t in_data,
  input  logic             cq_full,
  output logic             cq_push,
  output ppt_pkg::op_t     cq_op
);

  assign cq_push = in_push && !cq_full;

  always_comb begin
    cq_op.opcode       = ppt_pkg::OP_NOP;
    cq_op.coord_x      = in_data.coord_x;
    cq_op.coord_y      = in_data.coord_y;
    cq_op.button_index = in_data.button_index;
    cq_op.device       = in_data.source_device;
    cq_op.quiet        = (in_data.source_device == '0);
    unique case (in_data.cmd)
      ppt_pkg::CMD_MOVE: begin
        cq_op.opcode = in_data.is_relative ? ppt_pkg::OP_MOVE_REL : ppt_pkg::OP_MOVE_ABS;
      end
      ppt_pkg::CMD_BUTTON: begin
        // Buttons beyond the supported count are dropped here.
        if (32'(in_data.button_index) < ppt_pkg::BUTTON_COUNT) begin
          cq_op.opcode = in_data.pressed ? ppt_pkg::OP_BTN_SET : ppt_pkg::OP_BTN_CLR;
        end
      end
      ppt_pkg::CMD_QUERY: begin
        cq_op.opcode = ppt_pkg::OP_QUERY;
      end
      ppt_pkg::CMD_UNUSED: begin
        cq_op.opcode = ppt_pkg::OP_NOP;
      end
    endcase
  end

endmodule

// ----- rtl/ppt_back.sv -----
// Execute stage: holds view limits, cursor, accumulators and button mask.
module ppt_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppt_pkg::VIEW_W-1:0]      cfg_wdata,
  input  logic                            op_valid,
  input  ppt_pkg::op_t                    op,
  output logic                            op_take,
  input  logic                            res_full,
  output logic                            res_push,
  output ppt_pkg::out_item_t              res
);

  localparam int CUR_W   = ppt_pkg::CUR_W;
  localparam int SUM_W   = ppt_pkg::SUM_W;
  localparam int COORD_W = ppt_pkg::COORD_W;

  logic [CUR_W-1:0]          lim_x_r, lim_y_r;
  logic [CUR_W-1:0]          cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0]        accum_x_r, accum_x_nxt, accum_y_r, accum_y_nxt;
  logic [ppt_pkg::MASK_W-1:0] btn_r, btn_nxt, btn_new, btn_bit;

  logic                      fire, is_rel;
  logic signed [SUM_W-1:0]   cur_xs, cur_ys, cx_s, cy_s, tx, ty, lim_xs, lim_ys;
  logic [CUR_W-1:0]          nx, ny;
  logic [CUR_W:0]            dxa, dya;
  logic [COORD_W-1:0]        rx, ry;

  assign fire     = op_valid && !res_full;
  assign op_take  = fire;
  assign res_push = fire;

  // Move datapath: target, clamp into view, reported delta.
  always_comb begin
    is_rel = (op.opcode == ppt_pkg::OP_MOVE_REL);
    cur_xs = $signed({{(SUM_W-CUR_W){1'b0}}, cur_x_r});
    cur_ys = $signed({{(SUM_W-CUR_W){1'b0}}, cur_y_r});
    lim_xs = $signed({{(SUM_W-CUR_W){1'b0}}, lim_x_r});
    lim_ys = $signed({{(SUM_W-CUR_W){1'b0}}, lim_y_r});
    cx_s   = $signed({{(SUM_W-COORD_W){op.coord_x[COORD_W-1]}}, op.coord_x});
    cy_s   = $signed({{(SUM_W-COORD_W){op.coord_y[COORD_W-1]}}, op.coord_y});
    tx     = is_rel ? cur_xs + cx_s : cx_s;
    ty     = is_rel ? cur_ys + cy_s : cy_s;
    if (tx[SUM_W-1]) begin
      nx = '0;
    end else if (tx > lim_xs) begin
      nx = lim_x_r;
    end else begin
      nx = tx[CUR_W-1:0];
    end
    if (ty[SUM_W-1]) begin
      ny = '0;
    end else if (ty > lim_ys) begin
      ny = lim_y_r;
    end else begin
      ny = ty[CUR_W-1:0];
    end
    dxa = {1'b0, nx} - {1'b0, cur_x_r};
    dya = {1'b0, ny} - {1'b0, cur_y_r};
    rx  = is_rel ? op.coord_x : {{(COORD_W-CUR_W-1){dxa[CUR_W]}}, dxa};
    ry  = is_rel ? op.coord_y : {{(COORD_W-CUR_W-1){dya[CUR_W]}}, dya};
  end

  always_comb begin
    btn_bit = ppt_pkg::MASK_W'(1) << op.button_index;
    btn_new = (op.opcode == ppt_pkg::OP_BTN_SET) ? (btn_r | btn_bit) : (btn_r & ~btn_bit);
  end

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    accum_x_nxt = accum_x_r;
    accum_y_nxt = accum_y_r;
    btn_nxt     = btn_r;

    res.event_kind   = ppt_pkg::KIND_NONE;
    res.event_device = op.device;
    res.event_button = '0;
    res.delta_x      = '0;
    res.delta_y      = '0;

    unique case (op.opcode)
      ppt_pkg::OP_MOVE_ABS, ppt_pkg::OP_MOVE_REL: begin
        cur_x_nxt   = nx;
        cur_y_nxt   = ny;
        accum_x_nxt = ppt_pkg::sat_add16(accum_x_r, rx);
        accum_y_nxt = ppt_pkg::sat_add16(accum_y_r, ry);
        if (!op.quiet) begin
          res.event_kind = ppt_pkg::KIND_MOVE;
          res.delta_x    = rx;
          res.delta_y    = ry;
        end
      end
      ppt_pkg::OP_BTN_SET, ppt_pkg::OP_BTN_CLR: begin
        btn_nxt = btn_new;
        if (btn_new != btn_r && !op.quiet) begin
          res.event_kind   = (op.opcode == ppt_pkg::OP_BTN_SET) ?
                             ppt_pkg::KIND_DOWN : ppt_pkg::KIND_UP;
          res.event_button = op.button_index;
        end
      end
      ppt_pkg::OP_QUERY: begin
        res.event_kind = ppt_pkg::KIND_QUERY;
        res.delta_x    = accum_x_r;
        res.delta_y    = accum_y_r;
        accum_x_nxt    = '0;
        accum_y_nxt    = '0;
      end
      default: begin
      end
    endcase

    res.button_state = btn_nxt;
    res.report_x     = ppt_pkg::REPORT_W'(cur_x_nxt);
    res.report_y     = ppt_pkg::REPORT_W'(cur_y_nxt);
  end

  // View limits are kept as the clamped maximum coordinate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r <= ppt_pkg::view_limit(ppt_pkg::VIEW_WIDTH_RESET);
      lim_y_r <= ppt_pkg::view_limit(ppt_pkg::VIEW_HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppt_pkg::CFG_VIEW_WIDTH:  lim_x_r <= ppt_pkg::view_limit(cfg_wdata);
        ppt_pkg::CFG_VIEW_HEIGHT: lim_y_r <= ppt_pkg::view_limit(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      accum_x_r <= '0;
      accum_y_r <= '0;
      btn_r     <= '0;
    end else if (fire) begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      accum_x_r <= accum_x_nxt;
      accum_y_r <= accum_y_nxt;
      btn_r     <= btn_nxt;
    end
  end

  // A query leaves both accumulators cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op.opcode == ppt_pkg::OP_QUERY) |=> (accum_x_r == '0 && accum_y_r == '0))
    else $error("accumulators not cleared after query");

  // After any move the cursor lies inside the view.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (op.opcode == ppt_pkg::OP_MOVE_ABS || op.opcode == ppt_pkg::OP_MOVE_REL))
    |=> (cur_x_r <= lim_x_r && cur_y_r <= lim_y_r))
    else $error("cursor outside view after move");

  // A button-down event always reports the pressed bit as held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.event_kind == ppt_pkg::KIND_DOWN) |-> res.button_state[res.event_button])
    else $error("button down event without held bit");

  // A button-up event always reports the released bit as clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.event_kind == ppt_pkg::KIND_UP) |-> !res.button_state[res.event_button])
    else $error("button up event with held bit");

endmodule

// ----- rtl/pointer_position_tracker_unit.sv -----
// Top level of the pointer position tracker: front end, op queue, execute stage, result queue.
//
// Usage. Input beats enter through a queue-style port: a beat is taken at a
// rising edge with in_push high and in_full low. Each beat is a move (absolute
// or relative), a button change or a query, and every beat yields exactly one
// result beat. Results leave through a second queue-style port: the oldest
// result sits on out_data while out_empty is low and is taken at an edge with
// out_pop high. The view size registers are written through cfg_we, cfg_index
// and cfg_wdata while no beat is in flight.
//
// Timing. A beat accepted at one edge is decoded into the op queue at that edge;
// the execute stage takes it from the op queue once the result queue has room and
// writes its result there, after which it shows on out_data and can be popped.
// One beat per cycle is sustained while the receiver keeps popping; the execute
// stage (add, clamp, saturate, mask update) is combinational between the queues.
//
// Reset (synchronous, rst_n low) empties both queues, zeroes cursor,
// accumulators and button mask, and sets the view to 640 by 480. When the
// receiver stops popping, the result queue fills, the execute stage holds, the
// op queue fills and in_full rises; nothing is dropped.
module pointer_position_tracker_unit #(
  parameter int QUEUE_DEPTH = ppt_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  ppt_pkg::in_item_t             in_data,
  output logic                          in_full,
  output logic                          out_empty,
  output ppt_pkg::out_item_t            out_data,
  input  logic                          out_pop,
  input  logic                          cfg_we,
  input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppt_pkg::VIEW_W-1:0]    cfg_wdata
);

  localparam int OP_BITS  = $bits(ppt_pkg::op_t);
  localparam int RES_BITS = $bits(ppt_pkg::out_item_t);

  logic               cq_push, cq_full, cq_empty, cq_pop;
  ppt_pkg::op_t       cq_in_op, cq_out_op;
  logic [OP_BITS-1:0] cq_dout;
  logic               rq_push, rq_full;
  ppt_pkg::out_item_t rq_in;
  logic [RES_BITS-1:0] rq_dout;

  assign in_full   = cq_full;
  assign cq_out_op = ppt_pkg::op_t'(cq_dout);
  assign out_data  = ppt_pkg::out_item_t'(rq_dout);

  ppt_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_op   (cq_in_op)
  );

  // Decoded operations wait here so the front end and execute stage stall apart.
  ppt_fifo #(
    .WIDTH (OP_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (cq_in_op),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  ppt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op_valid  (!cq_empty),
    .op        (cq_out_op),
    .op_take   (cq_pop),
    .res_full  (rq_full),
    .res_push  (rq_push),
    .res       (rq_in)
  );

  // Finished results wait here for the receiver.
  ppt_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .din   (rq_in),
    .full  (rq_full),
    .pop   (out_pop),
    .dout  (rq_dout),
    .empty (out_empty)
  );

endmodule

// ----- sim/ppt_event_checker.sv -----
// Scoreboard for the pointer position tracker: predicts every result beat and checks it.
module ppt_event_checker
  import ppt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  in_item_t             in_data,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VIEW_W-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   outstanding,
  output int                   checked
);

  logic [VIEW_W-1:0]         width_reg;
  logic [VIEW_W-1:0]         height_reg;
  logic [REPORT_W-1:0]       cursor_x;
  logic [REPORT_W-1:0]       cursor_y;
  logic signed [COORD_W-1:0] total_dx;
  logic signed [COORD_W-1:0] total_dy;
  logic [MASK_W-1:0]         held_mask;
  out_item_t                 pending_events[$];
  out_item_t                 predicted;
  out_item_t                 oldest;

  // Highest coordinate the view allows; sizes outside [1, MAX_VIEW] are pulled in.
  function automatic int last_coord(input logic [VIEW_W-1:0] size);
    int span;
    span = int'(size);
    if (span < 1) span = 1;
    if (span > MAX_VIEW) span = MAX_VIEW;
    return span - 1;
  endfunction

  function automatic int pull_into(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Accumulators stick at the 16-bit signed rails.
  function automatic logic signed [COORD_W-1:0] accumulate(
      input logic signed [COORD_W-1:0] acc, input int d);
    int s;
    s = int'(acc) + d;
    if (s > 32767) s = 32767;
    else if (s < -32768) s = -32768;
    return COORD_W'(s);
  endfunction

  task automatic track_pointer(input in_item_t beat, output out_item_t ev);
    int tx;
    int ty;
    int nx;
    int ny;
    int rx;
    int ry;
    logic [MASK_W-1:0] next_mask;
    ev = '0;
    ev.event_device = beat.source_device;
    case (beat.cmd)
      CMD_MOVE: begin
        tx = int'(beat.coord_x);
        ty = int'(beat.coord_y);
        if (beat.is_relative) begin
          tx = int'(cursor_x) + tx;
          ty = int'(cursor_y) + ty;
        end
        nx = pull_into(tx, last_coord(width_reg));
        ny = pull_into(ty, last_coord(height_reg));
        // Relative moves report the raw delta, absolute ones the clamped change.
        rx = beat.is_relative ? int'(beat.coord_x) : nx - int'(cursor_x);
        ry = beat.is_relative ? int'(beat.coord_y) : ny - int'(cursor_y);
        cursor_x = REPORT_W'(nx);
        cursor_y = REPORT_W'(ny);
        total_dx = accumulate(total_dx, rx);
        total_dy = accumulate(total_dy, ry);
        if (beat.source_device != '0) begin
          ev.event_kind = KIND_MOVE;
          ev.delta_x = COORD_W'(rx);
          ev.delta_y = COORD_W'(ry);
        end
      end
      CMD_BUTTON: begin
        if (int'(beat.button_index) < BUTTON_COUNT) begin
          next_mask = held_mask;
          next_mask[beat.button_index] = beat.pressed;
          if (next_mask != held_mask) begin
            held_mask = next_mask;
            if (beat.source_device != '0) begin
              ev.event_kind = beat.pressed ? KIND_DOWN : KIND_UP;
              ev.event_button = beat.button_index;
            end
          end
        end
      end
      CMD_QUERY: begin
        ev.event_kind = KIND_QUERY;
        ev.delta_x = total_dx;
        ev.delta_y = total_dy;
        total_dx = '0;
        total_dy = '0;
      end
      default: begin
      end
    endcase
    ev.button_state = held_mask;
    ev.report_x = cursor_x;
    ev.report_y = cursor_y;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t: result %0d, %s: expected 0x%0h, actual 0x%0h",
                 $time, checked, name, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = VIEW_WIDTH_RESET;
      height_reg = VIEW_HEIGHT_RESET;
      cursor_x = '0;
      cursor_y = '0;
      total_dx = '0;
      total_dy = '0;
      held_mask = '0;
      pending_events.delete();
      mismatches = 0;
      checked = 0;
      outstanding = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual 0x%0h", $time, out_data);
        end else begin
          oldest = pending_events.pop_front();
          compare_field("event_kind", oldest.event_kind, out_data.event_kind);
          compare_field("event_device", oldest.event_device, out_data.event_device);
          compare_field("event_button", oldest.event_button, out_data.event_button);
          compare_field("button_state", oldest.button_state, out_data.button_state);
          compare_field("report_x", oldest.report_x, out_data.report_x);
          compare_field("report_y", oldest.report_y, out_data.report_y);
          compare_field("delta_x", oldest.delta_x, out_data.delta_x);
          compare_field("delta_y", oldest.delta_y, out_data.delta_y);
          checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_VIEW_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == CFG_VIEW_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_push && !in_full) begin
        track_pointer(in_data, predicted);
        pending_events.push_back(predicted);
      end
      outstanding = pending_events.size();
    end
  end

endmodule

// ----- sim/tb_pointer_position_tracker_unit.sv -----
// Testbench top for the pointer position tracker: stimulus, flow control and verdict.
module tb_pointer_position_tracker_unit;
  import ppt_pkg::*;

  // The random part runs in phases, each under its own view size. The last
  // phase runs with no idling on either side.
  localparam int RANDOM_PHASES    = 8;
  localparam int BEATS_PER_PHASE  = 205;
  // The longest legal quiet stretch is the long output hold plus short
  // gaps; the watchdog allows many times that.
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT      = 1000;
  localparam int PRESSURE_PHASE   = 3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  in_item_t             in_data   = '0;
  logic                 in_full;
  logic                 out_empty;
  out_item_t            out_data;
  logic                 out_pop   = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_VIEW_WIDTH;
  logic [VIEW_W-1:0]    cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int checked;

  // Idling switches for the sender and the receiver.
  bit send_gaps = 1'b1;
  bit pop_gaps  = 1'b1;

  // The stimulus process asks for a long output hold by bumping
  // hold_requests; the receiver process counts the hold out on its own.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int pop_gap_left  = 0;
  int idle_cycles   = 0;
  int beats_sent    = 0;
  int views_used    = 0;

  always #5 clk = ~clk;

  pointer_position_tracker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ppt_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Receiver. It pops by default and drops out_pop in random bursts. A
  // requested long hold takes priority; during it the result queue fills,
  // the block backs up and in_full rises while the sender keeps offering
  // beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD_CYCLES - 1;
      out_pop <= 1'b0;
    end else if (pop_gap_left > 0) begin
      pop_gap_left <= pop_gap_left - 1;
      out_pop <= 1'b0;
    end else if (pop_gaps && $urandom_range(0, 7) == 0) begin
      pop_gap_left <= $urandom_range(0, 6);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: any beat moving on either side resets the count. A run that
  // goes quiet for too long is stuck and is failed here.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved on either side for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one beat and returns at the edge where it is taken. in_push stays
  // high afterwards, so back-to-back calls keep the input busy every cycle;
  // a random gap lowers it first.
  task automatic send_beat(input in_item_t beat);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  // Stops offering and waits for every expected result to come out. The
  // count is read at the falling edge, when the scoreboard has settled. It
  // then lets the pipeline go quiet before returning.
  task automatic wait_until_drained();
    in_push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both view registers on consecutive edges. Only called while the
  // block is idle.
  task automatic set_view(input logic [VIEW_W-1:0] w, input logic [VIEW_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= CFG_VIEW_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_VIEW_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    views_used++;
  endtask

  function automatic in_item_t beat_of(input logic [CMD_W-1:0] cmd, input int x, input int y,
                                       input bit rel, input int idx, input bit prs,
                                       input int dev);
    in_item_t b;
    b.cmd = cmd;
    b.coord_x = COORD_W'(x);
    b.coord_y = COORD_W'(y);
    b.is_relative = rel;
    b.button_index = BTN_W'(idx);
    b.pressed = prs;
    b.source_device = DEV_W'(dev);
    return b;
  endfunction

  // Random beat. All fields start fully random, so fields a command does not
  // use carry noise. Moves mostly stay near the view: small relative steps
  // and absolute positions just around the visible range, with full-range
  // values mixed in to reach clamping and accumulator saturation.
  function automatic in_item_t random_beat(input int span_x, input int span_y);
    logic [63:0] raw;
    in_item_t    b;
    int          pick;
    raw = {$urandom, $urandom};
    b = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b.cmd = CMD_MOVE;
      if (b.is_relative) begin
        if ($urandom_range(0, 4) != 0) begin
          b.coord_x = COORD_W'(int'($urandom_range(0, 128)) - 64);
          b.coord_y = COORD_W'(int'($urandom_range(0, 128)) - 64);
        end
      end else if ($urandom_range(0, 3) != 0) begin
        b.coord_x = COORD_W'($urandom_range(0, span_x + 4));
        b.coord_y = COORD_W'($urandom_range(0, span_y + 4));
      end
    end else if (pick < 75) begin
      b.cmd = CMD_BUTTON;
    end else if (pick < 90) begin
      b.cmd = CMD_QUERY;
    end else if (pick < 95) begin
      b.cmd = CMD_UNUSED;
    end
    // Device 0 silences moves and buttons but still changes state.
    if ($urandom_range(0, 9) == 0) b.source_device = '0;
    return b;
  endfunction

  initial begin
    int w;
    int h;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset view of 640 by 480.
    // A query right out of reset replies even from device 0.
    send_beat(beat_of(CMD_QUERY, 0, 0, 1'b0, 0, 1'b0, 0));
    // Absolute moves: inside, far past the top corner, far below zero.
    send_beat(beat_of(CMD_MOVE, 100, 50, 1'b0, 0, 1'b0, 1));
    send_beat(beat_of(CMD_MOVE, 32767, 32767, 1'b0, 0, 1'b0, 255));
    send_beat(beat_of(CMD_MOVE, -32768, -32768, 1'b0, 0, 1'b0, 2));
    // Largest relative steps push the accumulators to the positive rail.
    send_beat(beat_of(CMD_MOVE, 32767, 32767, 1'b1, 0, 1'b0, 3));
    send_beat(beat_of(CMD_MOVE, 32767, 32767, 1'b1, 0, 1'b0, 3));
    send_beat(beat_of(CMD_QUERY, 0, 0, 1'b0, 0, 1'b0, 9));
    // And the most negative ones to the negative rail.
    send_beat(beat_of(CMD_MOVE, -32768, -32768, 1'b1, 0, 1'b0, 4));
    send_beat(beat_of(CMD_MOVE, -32768, -32768, 1'b1, 0, 1'b0, 4));
    send_beat(beat_of(CMD_MOVE, -32768, -32768, 1'b1, 0, 1'b0, 4));
    send_beat(beat_of(CMD_QUERY, 0, 0, 1'b0, 0, 1'b0, 128));
    // A move from device 0 updates the cursor but reports nothing.
    send_beat(beat_of(CMD_MOVE, 300, 200, 1'b0, 0, 1'b0, 0));
    // Buttons: press, repeated press, top button, release, repeated release,
    // and a silent press from device 0.
    send_beat(beat_of(CMD_BUTTON, 0, 0, 1'b0, 0, 1'b1, 5));
    send_beat(beat_of(CMD_BUTTON, 0, 0, 1'b0, 0, 1'b1, 5));
    send_beat(beat_of(CMD_BUTTON, 0, 0, 1'b0, 7, 1'b1, 170));
    send_beat(beat_of(CMD_BUTTON, 0, 0, 1'b0, 0, 1'b0, 5));
    send_beat(beat_of(CMD_BUTTON, 0, 0, 1'b0, 0, 1'b0, 5));
    send_beat(beat_of(CMD_BUTTON, 0, 0, 1'b0, 3, 1'b1, 0));
    // The unused command changes nothing.
    send_beat(beat_of(CMD_UNUSED, 1234, -1234, 1'b1, 6, 1'b1, 7));
    send_beat(beat_of(CMD_MOVE, 600, 400, 1'b0, 0, 1'b0, 1));

    // Shrinking the view leaves the cursor where it was until the next move.
    wait_until_drained();
    set_view(13'd100, 13'd100);
    send_beat(beat_of(CMD_QUERY, 0, 0, 1'b0, 0, 1'b0, 1));
    send_beat(beat_of(CMD_MOVE, 0, 0, 1'b1, 0, 1'b0, 1));

    // A width of zero acts as one, a height above the maximum as the maximum.
    wait_until_drained();
    set_view(13'd0, 13'd8191);
    send_beat(beat_of(CMD_MOVE, 5000, 5000, 1'b0, 0, 1'b0, 6));
    send_beat(beat_of(CMD_MOVE, -1, 1, 1'b1, 0, 1'b0, 6));
    send_beat(beat_of(CMD_QUERY, 0, 0, 1'b0, 0, 1'b0, 6));

    // Random phases. Each starts from an idle block with a new view.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_until_drained();
      case (phase)
        0: begin w = 640;  h = 480;  end
        1: begin w = 1;    h = 1;    end
        2: begin w = 0;    h = 0;    end
        3: begin w = 4096; h = 4096; end
        4: begin w = 8191; h = 8191; end
        5: begin w = 4097; h = 2;    end
        6: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
        default: begin w = $urandom_range(1, 700); h = $urandom_range(1, 700); end
      endcase
      set_view(VIEW_W'(w), VIEW_W'(h));
      if (phase == RANDOM_PHASES - 1) begin
        send_gaps = 1'b0;
        pop_gaps = 1'b0;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // Back-pressure: a long output hold while beats keep coming, and
        // later a pause until every expected result has come out.
        if (phase == PRESSURE_PHASE && n == 100) hold_requests++;
        if (phase == PRESSURE_PHASE && n == 150) wait_until_drained();
        send_beat(random_beat(w, h));
      end
    end

    wait_until_drained();
    $display("Run covered %0d beats: directed edge cases, then %0d random phases over %0d views,",
             beats_sent, RANDOM_PHASES, views_used);
    $display("with a long output hold and a mid-run drain; %0d results checked, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
